FILE: rtl/pbfe_pkg.sv
// ----------------------------------------------------------------------------
// Plane basis package
// Shared widths, codes, handshake types and saturation helper for the plane
// basis block.
// ----------------------------------------------------------------------------
package pbfe_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int W             = 32;
   localparam int OPW           = 33;
   localparam int PROD_W        = 2 * OPW;
   localparam int RAD_W         = 64;
   localparam int TOL_W         = 17;

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1);
   localparam logic [W-1:0]     REV_RESET = '1;

   localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(64'sh7FFF_FFFF);
   localparam logic signed [PROD_W-1:0] SAT_MIN = -SAT_MAX - PROD_W'(1);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SQ_A,
      S_SQ_C,
      S_SUM,
      S_ROOT,
      S_CHECK,
      S_DIV_X,
      S_DIV_Z,
      S_PROD,
      S_DONE
   } state_type;

   typedef enum logic {
      OP_SQRT,
      OP_DIV
   } op_type;

   typedef enum logic [2:0] {
      P_FWD_X,
      P_FY_A,
      P_FY_B,
      P_FWD_Z,
      P_SHIFT_X,
      P_SHIFT_Y,
      P_SHIFT_Z,
      P_END
   } prod_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

   function automatic logic signed [W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [W-1:0] r;
      if (v > SAT_MAX) begin
         r = SAT_MAX[W-1:0];
      end else if (v < SAT_MIN) begin
         r = SAT_MIN[W-1:0];
      end else begin
         r = v[W-1:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/plane_basis_from_equation_top.sv
// ----------------------------------------------------------------------------
// Plane basis from plane equation
// Turns a fixed-point plane equation into left, normal, forward and shift
// vectors whenever its revision changes.
// ----------------------------------------------------------------------------
// A request whose revision matches the last one handled produces no response.
// Any other request occupies the block until its response is formed; when the
// normal is treated as vertical the two divisions are skipped. Almost all of
// the time is spent in the shift-subtract unit, which produces one bit per cycle
// of the square root and of the two divisions; a single registered multiplier
// forms the nine products one per cycle. A new request is accepted once the
// previous response has been moved into the output register, even if that
// response is still stalled.
module plane_basis_from_equation_top
   import pbfe_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [TOL_W-1:0]     csr_wr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [W-1:0]  req_plane_a,
   input  logic signed [W-1:0]  req_plane_b,
   input  logic signed [W-1:0]  req_plane_c,
   input  logic signed [W-1:0]  req_plane_d,
   input  logic [W-1:0]         req_revision,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [W-1:0]  rsp_left_x,
   output logic signed [W-1:0]  rsp_left_z,
   output logic signed [W-1:0]  rsp_normal_x,
   output logic signed [W-1:0]  rsp_normal_y,
   output logic signed [W-1:0]  rsp_normal_z,
   output logic signed [W-1:0]  rsp_forward_x,
   output logic signed [W-1:0]  rsp_forward_y,
   output logic signed [W-1:0]  rsp_forward_z,
   output logic signed [W-1:0]  rsp_shift_x,
   output logic signed [W-1:0]  rsp_shift_y,
   output logic signed [W-1:0]  rsp_shift_z,
   output logic                 rsp_degenerate
);

   localparam int QW = W + FRAC_BITS;
   localparam logic signed [W-1:0] ONE = W'(1) << FRAC_BITS;

   state_type state_ff, state_in;
   prod_type  pcnt_ff,  pcnt_in;
   logic [W-1:0]     last_rev_ff, last_rev_in;
   logic [TOL_W-1:0] tol_ff,      tol_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic signed [W-1:0] pa_ff, pa_in, pb_ff, pb_in, pc_ff, pc_in, pd_ff, pd_in;
   logic [RAD_W-1:0]    sum_ff, sum_in;
   logic [W-1:0]        len_ff, len_in;
   logic signed [W-1:0] lx_ff, lx_in, lz_ff, lz_in;
   logic                degen_ff, degen_in;
   logic signed [PROD_W-1:0] fy_acc_ff, fy_acc_in;
   logic signed [W-1:0] fwd_x_ff, fwd_x_in, fwd_y_ff, fwd_y_in, fwd_z_ff, fwd_z_in;
   logic signed [W-1:0] shx_ff, shx_in, shy_ff, shy_in, shz_ff, shz_in;

   logic signed [W-1:0] o_lx_ff, o_lz_ff, o_nx_ff, o_ny_ff, o_nz_ff;
   logic signed [W-1:0] o_fx_ff, o_fy_ff, o_fz_ff, o_sx_ff, o_sy_ff, o_sz_ff;
   logic                o_dg_ff;

   logic req_accept;
   logic new_req;
   logic rsp_load;
   logic degen_now;

   unit_ctl_type        unit_ctl;
   unit_stat_type       unit_stat;
   logic [RAD_W-1:0]    radicand;
   logic [W-1:0]        dvd_mag;
   logic [QW-1:0]       unit_q;
   logic                q_over;
   logic [W-1:0]        div_pos;
   logic [W-1:0]        div_neg;
   logic [W-1:0]        abs_a;
   logic [W-1:0]        abs_c;

   logic signed [OPW-1:0]    mul_a, mul_b, nd;
   logic signed [PROD_W-1:0] prod;
   logic signed [PROD_W-1:0] prod_sh;

   pbfe_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (prod)
   );

   pbfe_shsub #(
      .FRAC_BITS (FRAC_BITS)
   ) u_shsub (
      .clock    (clock),
      .reset    (reset),
      .ctl      (unit_ctl),
      .radicand (radicand),
      .dvd_mag  (dvd_mag),
      .divisor  (len_ff),
      .stat     (unit_stat),
      .result   (unit_q)
   );

   assign req_accept = req_valid && !req_stall;
   assign new_req    = req_accept && (req_revision != last_rev_ff);
   assign degen_now  = (len_ff == '0) || (len_ff < W'(tol_ff));
   assign abs_a      = pa_ff[W-1] ? -pa_ff : pa_ff;
   assign abs_c      = pc_ff[W-1] ? -pc_ff : pc_ff;
   assign nd         = -OPW'(pd_ff);
   assign prod_sh    = prod >>> FRAC_BITS;
   assign radicand   = sum_ff + prod[RAD_W-1:0];
   assign q_over     = |unit_q[QW-1:W-1];
   assign div_pos    = q_over ? SAT_MAX[W-1:0] : unit_q[W-1:0];
   assign div_neg    = q_over ? SAT_MIN[W-1:0] : -unit_q[W-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (new_req) begin
               state_in = S_SQ_A;
            end
         end
         S_SQ_A: begin
            state_in = S_SQ_C;
         end
         S_SQ_C: begin
            state_in = S_SUM;
         end
         S_SUM: begin
            state_in = S_ROOT;
         end
         S_ROOT: begin
            if (unit_stat.done) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = degen_now ? S_PROD : S_DIV_X;
         end
         S_DIV_X: begin
            if (unit_stat.done) begin
               state_in = S_DIV_Z;
            end
         end
         S_DIV_Z: begin
            if (unit_stat.done) begin
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            if (pcnt_ff == P_END) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall      = (state_ff != S_IDLE);
      rsp_load       = 1'b0;
      unit_ctl.start = 1'b0;
      unit_ctl.op    = OP_DIV;
      dvd_mag        = abs_c;
      mul_a          = '0;
      mul_b          = '0;
      case (state_ff)
         S_SQ_A: begin
            mul_a = OPW'(pa_ff);
            mul_b = OPW'(pa_ff);
         end
         S_SQ_C: begin
            mul_a = OPW'(pc_ff);
            mul_b = OPW'(pc_ff);
         end
         S_SUM: begin
            unit_ctl.start = 1'b1;
            unit_ctl.op    = OP_SQRT;
         end
         S_CHECK: begin
            unit_ctl.start = !degen_now;
         end
         S_DIV_X: begin
            unit_ctl.start = unit_stat.done;
            dvd_mag        = abs_a;
         end
         S_PROD: begin
            case (pcnt_ff)
               P_FWD_X: begin
                  mul_a = OPW'(lz_ff);
                  mul_b = OPW'(pb_ff);
               end
               P_FY_A: begin
                  mul_a = OPW'(lx_ff);
                  mul_b = OPW'(pc_ff);
               end
               P_FY_B: begin
                  mul_a = OPW'(lz_ff);
                  mul_b = OPW'(pa_ff);
               end
               P_FWD_Z: begin
                  mul_a = OPW'(lx_ff);
                  mul_b = OPW'(pb_ff);
               end
               P_SHIFT_X: begin
                  mul_a = OPW'(pa_ff);
                  mul_b = nd;
               end
               P_SHIFT_Y: begin
                  mul_a = OPW'(pb_ff);
                  mul_b = nd;
               end
               P_SHIFT_Z: begin
                  mul_a = OPW'(pc_ff);
                  mul_b = nd;
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         S_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            rsp_load = 1'b0;
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      pcnt_in      = pcnt_ff;
      last_rev_in  = last_rev_ff;
      tol_in       = csr_wr_en ? csr_wr_data : tol_ff;
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      pc_in        = pc_ff;
      pd_in        = pd_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      lx_in        = lx_ff;
      lz_in        = lz_ff;
      degen_in     = degen_ff;
      fy_acc_in    = fy_acc_ff;
      fwd_x_in     = fwd_x_ff;
      fwd_y_in     = fwd_y_ff;
      fwd_z_in     = fwd_z_ff;
      shx_in       = shx_ff;
      shy_in       = shy_ff;
      shz_in       = shz_ff;
      if (new_req) begin
         last_rev_in = req_revision;
         pa_in       = req_plane_a;
         pb_in       = req_plane_b;
         pc_in       = req_plane_c;
         pd_in       = req_plane_d;
      end
      case (state_ff)
         S_SQ_C: begin
            sum_in = prod[RAD_W-1:0];
         end
         S_ROOT: begin
            if (unit_stat.done) begin
               len_in = unit_q[W-1:0];
            end
         end
         S_CHECK: begin
            pcnt_in  = P_FWD_X;
            degen_in = degen_now;
            if (degen_now) begin
               lx_in = ONE;
               lz_in = '0;
            end
         end
         S_DIV_X: begin
            if (unit_stat.done) begin
               lx_in = pc_ff[W-1] ? div_neg : div_pos;
            end
         end
         S_DIV_Z: begin
            if (unit_stat.done) begin
               lz_in = (!pa_ff[W-1] && (pa_ff != '0)) ? div_neg : div_pos;
            end
         end
         S_PROD: begin
            pcnt_in = prod_type'(pcnt_ff + 3'd1);
            // Each count consumes the product issued in the cycle before.
            case (pcnt_ff)
               P_FY_A: begin
                  fwd_x_in = sat32(prod_sh);
               end
               P_FY_B: begin
                  fy_acc_in = prod_sh;
               end
               P_FWD_Z: begin
                  fwd_y_in = sat32(fy_acc_ff - prod_sh);
               end
               P_SHIFT_X: begin
                  fwd_z_in = sat32(-prod_sh);
               end
               P_SHIFT_Y: begin
                  shx_in = sat32(prod_sh);
               end
               P_SHIFT_Z: begin
                  shy_in = sat32(prod_sh);
               end
               P_END: begin
                  shz_in = sat32(prod_sh);
               end
               default: begin
                  fy_acc_in = fy_acc_ff;
               end
            endcase
         end
         default: begin
            sum_in = sum_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pcnt_ff      <= P_FWD_X;
         last_rev_ff  <= REV_RESET;
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pcnt_ff      <= pcnt_in;
         last_rev_ff  <= last_rev_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pa_ff     <= pa_in;
      pb_ff     <= pb_in;
      pc_ff     <= pc_in;
      pd_ff     <= pd_in;
      sum_ff    <= sum_in;
      len_ff    <= len_in;
      lx_ff     <= lx_in;
      lz_ff     <= lz_in;
      degen_ff  <= degen_in;
      fy_acc_ff <= fy_acc_in;
      fwd_x_ff  <= fwd_x_in;
      fwd_y_ff  <= fwd_y_in;
      fwd_z_ff  <= fwd_z_in;
      shx_ff    <= shx_in;
      shy_ff    <= shy_in;
      shz_ff    <= shz_in;
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         o_lx_ff <= lx_ff;
         o_lz_ff <= lz_ff;
         o_nx_ff <= pa_ff;
         o_ny_ff <= pb_ff;
         o_nz_ff <= pc_ff;
         o_fx_ff <= fwd_x_ff;
         o_fy_ff <= fwd_y_ff;
         o_fz_ff <= fwd_z_ff;
         o_sx_ff <= shx_ff;
         o_sy_ff <= shy_ff;
         o_sz_ff <= shz_ff;
         o_dg_ff <= degen_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_x     = o_lx_ff;
   assign rsp_left_z     = o_lz_ff;
   assign rsp_normal_x   = o_nx_ff;
   assign rsp_normal_y   = o_ny_ff;
   assign rsp_normal_z   = o_nz_ff;
   assign rsp_forward_x  = o_fx_ff;
   assign rsp_forward_y  = o_fy_ff;
   assign rsp_forward_z  = o_fz_ff;
   assign rsp_shift_x    = o_sx_ff;
   assign rsp_shift_y    = o_sy_ff;
   assign rsp_shift_z    = o_sz_ff;
   assign rsp_degenerate = o_dg_ff;

   a_repeat_ignored: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_revision == last_rev_ff)) |=> (state_ff == S_IDLE))
      else $error("A request with a repeated revision started work.");

   a_unit_free: assert property (@(posedge clock) disable iff (reset)
      unit_ctl.start |-> !unit_stat.busy)
      else $error("The shift-subtract unit was started while busy.");

   a_prod_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROD) |-> !unit_stat.busy)
      else $error("The shift-subtract unit was still busy during the products.");

   a_degenerate_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> ((rsp_left_z == '0) && (rsp_left_x == ONE)))
      else $error("A degenerate response carries the wrong left vector.");

endmodule

FILE: rtl/pbfe_mul.sv
// ----------------------------------------------------------------------------
// Plane basis multiplier
// Signed 33 by 33 bit multiplier with a registered product, shared by every
// product of the block.
// ----------------------------------------------------------------------------
module pbfe_mul
   import pbfe_pkg::*;
(
   input  logic                     clock,
   input  logic signed [OPW-1:0]    mul_a,
   input  logic signed [OPW-1:0]    mul_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   always_comb begin
      prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: rtl/pbfe_shsub.sv
// ----------------------------------------------------------------------------
// Plane basis shift-subtract unit
// Iterative restoring unit that produces one result bit per cycle, either of
// an integer square root or of an unsigned division.
// ----------------------------------------------------------------------------
module pbfe_shsub
   import pbfe_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  unit_ctl_type               ctl,
   input  logic [RAD_W-1:0]           radicand,
   input  logic [W-1:0]               dvd_mag,
   input  logic [W-1:0]               divisor,
   output unit_stat_type              stat,
   output logic [W+FRAC_BITS-1:0]     result
);

   localparam int QW = W + FRAC_BITS;
   localparam int CW = $clog2(QW + 1);
   localparam int RW = W + 2;
   localparam int TW = RW + 2;

   logic [RW-1:0]    rem_ff,  rem_in;
   logic [RAD_W-1:0] sh_ff,   sh_in;
   logic [QW-1:0]    q_ff,    q_in;
   logic [W-1:0]     div_ff,  div_in;
   logic [CW-1:0]    cnt_ff,  cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   op_type           op_ff,   op_in;

   logic [TW-1:0] rem_t;
   logic [TW-1:0] trial;
   logic [TW-1:0] diff;
   logic          ge;

   always_comb begin
      if (op_ff == OP_SQRT) begin
         rem_t = {rem_ff, sh_ff[RAD_W-1 -: 2]};
         trial = {2'b00, q_ff[W-1:0], 2'b01};
      end else begin
         rem_t = {1'b0, rem_ff, sh_ff[RAD_W-1]};
         trial = TW'(div_ff);
      end
      diff = rem_t - trial;
      ge   = (rem_t >= trial);
   end

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      op_in   = op_ff;
      done_in = 1'b0;
      if (ctl.start && !busy_ff) begin
         op_in   = ctl.op;
         rem_in  = '0;
         q_in    = '0;
         div_in  = divisor;
         busy_in = 1'b1;
         if (ctl.op == OP_SQRT) begin
            sh_in  = radicand;
            cnt_in = CW'(W);
         end else begin
            sh_in  = {dvd_mag, {(RAD_W-W){1'b0}}};
            cnt_in = CW'(QW);
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[RW-1:0] : rem_t[RW-1:0];
         q_in   = {q_ff[QW-2:0], ge};
         sh_in  = (op_ff == OP_SQRT) ? (sh_ff << 2) : (sh_ff << 1);
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         op_ff   <= OP_SQRT;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         op_ff   <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
      div_ff <= div_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = q_ff;

endmodule

FILE: tb/tb_plane_basis_from_equation_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Plane basis block testbench
// Drives plane equations with changing and repeated revisions through the
// valid/stall request channel, predicts each basis from a cycle-free model of
// the fixed-point arithmetic and checks every response field against it, under
// random idling on both sides, a long response hold-off and several tolerance
// settings.
// ----------------------------------------------------------------------------
module tb_plane_basis_from_equation_top;
   import pbfe_pkg::*;

   localparam int FRAC      = FRAC_BITS_DEF;
   localparam int BASIS_W   = 11 * W + 1;
   localparam int SETTLE    = 200;
   localparam int LONG_HOLD = 1500;
   localparam int STUCK_MAX = 8000;
   localparam int PER_PHASE = 200;

   typedef struct packed {
      logic signed [W-1:0] left_x;
      logic signed [W-1:0] left_z;
      logic signed [W-1:0] normal_x;
      logic signed [W-1:0] normal_y;
      logic signed [W-1:0] normal_z;
      logic signed [W-1:0] forward_x;
      logic signed [W-1:0] forward_y;
      logic signed [W-1:0] forward_z;
      logic signed [W-1:0] shift_x;
      logic signed [W-1:0] shift_y;
      logic signed [W-1:0] shift_z;
      logic                degenerate;
   } basis_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [TOL_W-1:0]    csr_wr_data = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic signed [W-1:0] req_plane_a = '0;
   logic signed [W-1:0] req_plane_b = '0;
   logic signed [W-1:0] req_plane_c = '0;
   logic signed [W-1:0] req_plane_d = '0;
   logic [W-1:0]        req_revision = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   basis_type           rsp_basis;

   basis_type           basis_due [$];
   logic [TOL_W-1:0]    model_tol = TOL_RESET;
   logic [W-1:0]        model_rev = REV_RESET;
   int                  planes_changed = 0;
   int                  errors = 0;
   bit                  idle_on = 1'b1;
   int                  hold_asked = 0;
   int                  hold_served = 0;
   int                  hold_left = 0;
   int                  burst_left = 0;
   int                  stuck = 0;
   string               field_names [12] = '{"left_x", "left_z", "normal_x", "normal_y",
                                             "normal_z", "forward_x", "forward_y",
                                             "forward_z", "shift_x", "shift_y", "shift_z",
                                             "degenerate"};

   plane_basis_from_equation_top u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_plane_a    (req_plane_a),
      .req_plane_b    (req_plane_b),
      .req_plane_c    (req_plane_c),
      .req_plane_d    (req_plane_d),
      .req_revision   (req_revision),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_left_x     (rsp_basis.left_x),
      .rsp_left_z     (rsp_basis.left_z),
      .rsp_normal_x   (rsp_basis.normal_x),
      .rsp_normal_y   (rsp_basis.normal_y),
      .rsp_normal_z   (rsp_basis.normal_z),
      .rsp_forward_x  (rsp_basis.forward_x),
      .rsp_forward_y  (rsp_basis.forward_y),
      .rsp_forward_z  (rsp_basis.forward_z),
      .rsp_shift_x    (rsp_basis.shift_x),
      .rsp_shift_y    (rsp_basis.shift_y),
      .rsp_shift_z    (rsp_basis.shift_z),
      .rsp_degenerate (rsp_basis.degenerate)
   );

   always #5 clock = ~clock;

   function automatic logic signed [W-1:0] clamp_q(input longint v);
      if (v > 64'sd2147483647) begin
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[W-1:0];
   endfunction

   function automatic longint q_mul(input longint x, input longint y);
      return (x * y) >>> FRAC;
   endfunction

   function automatic logic [63:0] root_floor(input logic [63:0] n);
      logic [31:0] r;
      logic [31:0] t;
      r = '0;
      for (int i = 31; i >= 0; i--) begin
         t = r | (32'd1 << i);
         if ({32'd0, t} * {32'd0, t} <= n) begin
            r = t;
         end
      end
      return {32'd0, r};
   endfunction

   function automatic longint q_div(input longint v, input logic [63:0] len);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      q = (mag << FRAC) / len;
      if (q > 64'h8000_0000) begin
         q = 64'h8000_0000;
      end
      return clamp_q((v < 0) ? -longint'(q) : longint'(q));
   endfunction

   function automatic basis_type predict_basis(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b,
                                               input logic signed [W-1:0] c,
                                               input logic signed [W-1:0] d);
      basis_type   r;
      longint      la;
      longint      lb;
      longint      lc;
      longint      nd;
      longint      lx;
      longint      lz;
      logic [63:0] len;
      la = a;
      lb = b;
      lc = c;
      nd = -longint'(d);
      len = root_floor(64'(la * la) + 64'(lc * lc));
      if (len == 0 || len < {47'd0, model_tol}) begin
         lx = longint'(1) << FRAC;
         lz = 0;
         r.degenerate = 1'b1;
      end else begin
         lx = q_div(lc, len);
         lz = q_div(-la, len);
         r.degenerate = 1'b0;
      end
      r.left_x    = clamp_q(lx);
      r.left_z    = clamp_q(lz);
      r.normal_x  = a;
      r.normal_y  = b;
      r.normal_z  = c;
      r.forward_x = clamp_q(q_mul(lz, lb));
      r.forward_y = clamp_q(q_mul(lx, lc) - q_mul(lz, la));
      r.forward_z = clamp_q(-q_mul(lx, lb));
      r.shift_x   = clamp_q(q_mul(la, nd));
      r.shift_y   = clamp_q(q_mul(lb, nd));
      r.shift_z   = clamp_q(q_mul(lc, nd));
      return r;
   endfunction

   function automatic logic signed [W-1:0] rand_q();
      logic signed [W-1:0] v;
      case ($urandom_range(0, 7))
         0: begin
            v = W'($urandom_range(0, 262143)) - 32'sd131072;
         end
         1: begin
            v = W'($urandom_range(0, 63)) - 32'sd32;
         end
         2: begin
            case ($urandom_range(0, 5))
               0: v = 32'sh8000_0000;
               1: v = 32'sh7FFF_FFFF;
               2: v = '0;
               3: v = 32'sh0001_0000;
               4: v = 32'shFFFF_0000;
               default: v = '1;
            endcase
         end
         default: begin
            v = $urandom;
         end
      endcase
      return v;
   endfunction

   function automatic logic [W-1:0] pick_revision();
      case ($urandom_range(0, 19))
         0, 1, 2: return model_rev;
         3, 4:    return $urandom;
         default: return model_rev + 1 + $urandom_range(0, 3);
      endcase
   endfunction

   task automatic send_plane(input logic signed [W-1:0] a, input logic signed [W-1:0] b,
                             input logic signed [W-1:0] c, input logic signed [W-1:0] d,
                             input logic [W-1:0] rev);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_plane_a  <= a;
      req_plane_b  <= b;
      req_plane_c  <= c;
      req_plane_d  <= d;
      req_revision <= rev;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (rev != model_rev) begin
         model_rev = rev;
         basis_due.push_back(predict_basis(a, b, c, d));
         planes_changed++;
      end
   endtask

   task automatic send_random_plane(input logic [W-1:0] rev);
      send_plane(rand_q(), rand_q(), rand_q(), rand_q(), rev);
   endtask

   task automatic set_tolerance(input logic [TOL_W-1:0] value);
      req_valid <= 1'b0;
      while (basis_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_tol = value;
   endtask

   task automatic test_reset_revision();
      send_plane(32'sh0001_0000, 32'sd2, 32'sd3, 32'sd4, '1);
      send_plane(32'sh0002_0000, 32'sd0, 32'sd0, 32'sd0, '1);
      send_plane(32'sh0002_0000, 32'sd0, 32'sd0, 32'sd0, 32'd0);
   endtask

   task automatic test_field_extremes();
      send_plane('0, '0, '0, '0, 32'd1);
      send_plane(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'd2);
      send_plane(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'd3);
      send_plane(32'sh7FFF_FFFF, 32'sh8000_0000, '0, 32'sh7FFF_FFFF, 32'd4);
      send_plane('0, 32'sh0001_0000, '0, 32'shFFFF_0000, 32'd5);
      send_plane(32'sh0001_0000, '0, 32'sh0001_0000, 32'sh0003_8000, 32'd6);
      send_plane('1, 32'sh0123_4567, 32'sd1, 32'sh8000_0000, 32'h7FFF_FFFF);
      send_plane(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'h8000_0000);
      send_plane(32'shFFFE_8000, 32'sh0000_4000, 32'sh0002_0000, 32'sh0010_0000, 32'hFFFF_FFFE);
   endtask

   task automatic test_repeated_revision();
      send_plane(32'sh0003_0000, 32'sh0001_0000, 32'shFFFC_0000, 32'sd5, 32'h0000_1234);
      send_plane(32'sh0005_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sd9, 32'h0000_1234);
      send_plane(32'sh0005_0000, 32'sh0002_0000, 32'sh0001_0000, 32'sd9, 32'h0000_1235);
   endtask

   task automatic test_tolerance_edges();
      set_tolerance(TOL_W'(300));
      send_plane(32'sd300, 32'sh0001_0000, '0, 32'sh0001_0000, 32'd10);
      send_plane(32'sd299, 32'sh0001_0000, '0, 32'sh0001_0000, 32'd11);
      send_plane('0, 32'sh0001_0000, -32'sd300, 32'sh0001_0000, 32'd12);
      set_tolerance('0);
      send_plane('0, 32'sh0004_0000, '0, 32'sh0002_0000, 32'd13);
      send_plane(32'sd1, 32'sh0004_0000, '0, 32'sh0002_0000, 32'd14);
      set_tolerance(TOL_W'(65536));
      send_plane(32'sh0001_0000, 32'sd7, '0, 32'sd7, 32'd15);
      send_plane(32'sh0000_FFFF, 32'sd7, '0, 32'sd7, 32'd16);
      set_tolerance('1);
      send_plane('0, 32'sd7, 32'sh0001_FFFE, 32'sd7, 32'd17);
      send_plane('0, 32'sd7, 32'sh0001_FFFF, 32'sd7, 32'd18);
   endtask

   task automatic test_output_backpressure();
      set_tolerance(TOL_RESET);
      hold_asked++;
      repeat (6) send_random_plane(model_rev + 1);
   endtask

   task automatic test_random_planes();
      logic [TOL_W-1:0] tols [6];
      int               goal;
      tols = '{'0, TOL_W'(65536), '1, TOL_W'($urandom_range(0, 131071)),
               TOL_W'($urandom_range(0, 4096)), TOL_RESET};
      for (int p = 0; p < 6; p++) begin
         set_tolerance(tols[p]);
         idle_on = (p != 5);
         goal = planes_changed + PER_PHASE;
         while (planes_changed < goal) begin
            send_random_plane(pick_revision());
         end
      end
   endtask

   always @(posedge clock) begin
      if (hold_asked != hold_served) begin
         hold_left = LONG_HOLD;
         hold_served = hold_asked;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!idle_on || reset) begin
         rsp_stall <= 1'b0;
      end else if (burst_left > 0) begin
         burst_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 5) == 0) begin
         burst_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      logic [BASIS_W-1:0] want;
      logic [BASIS_W-1:0] got;
      logic [W-1:0]       e;
      logic [W-1:0]       g;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (basis_due.size() == 0) begin
            $display("%0t: response with no request pending", $time);
            errors++;
         end else begin
            want = basis_due.pop_front();
            got = rsp_basis;
            for (int k = 0; k < 12; k++) begin
               if (k < 11) begin
                  e = want[BASIS_W-1-W*k -: W];
                  g = got[BASIS_W-1-W*k -: W];
               end else begin
                  e = {31'd0, want[0]};
                  g = {31'd0, got[0]};
               end
               if (e !== g) begin
                  $display("%0t: %s expected %h actual %h", $time, field_names[k], e, g);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_wr_en || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck <= 0;
      end else begin
         stuck <= stuck + 1;
      end
      if (stuck >= STUCK_MAX) begin
         $display("%0t: no handshake for %0d cycles", $time, stuck);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_revision();
      test_field_extremes();
      test_repeated_revision();
      test_tolerance_edges();
      test_output_backpressure();
      test_random_planes();
      req_valid <= 1'b0;
      while (basis_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/pbfe_pkg.sv
rtl/pbfe_mul.sv
rtl/pbfe_shsub.sv
rtl/plane_basis_from_equation_top.sv
tb/tb_plane_basis_from_equation_top.sv
